// ===== rtl/core/vif_pkg.sv =====
package vif_pkg;

  localparam int KEY_FIFO_DEPTH_DEF = 16;
  localparam int TIMER_W = 16;
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 32;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_PUSH  = 2'd3
  } op_t;

  localparam logic [3:0] REG_ORB  = 4'd0;
  localparam logic [3:0] REG_ORA  = 4'd1;
  localparam logic [3:0] REG_DDRB = 4'd2;
  localparam logic [3:0] REG_DDRA = 4'd3;
  localparam logic [3:0] REG_T1CL = 4'd4;
  localparam logic [3:0] REG_T1CH = 4'd5;
  localparam logic [3:0] REG_T1LL = 4'd6;
  localparam logic [3:0] REG_T1LH = 4'd7;
  localparam logic [3:0] REG_T2CL = 4'd8;
  localparam logic [3:0] REG_T2CH = 4'd9;
  localparam logic [3:0] REG_SR   = 4'd10;
  localparam logic [3:0] REG_ACR  = 4'd11;
  localparam logic [3:0] REG_PCR  = 4'd12;
  localparam logic [3:0] REG_IFR  = 4'd13;
  localparam logic [3:0] REG_IER  = 4'd14;
  localparam logic [3:0] REG_ORA2 = 4'd15;

  // interrupt flag bit positions
  localparam int FLB_CA2 = 0;
  localparam int FLB_CA1 = 1;
  localparam int FLB_CB2 = 3;
  localparam int FLB_CB1 = 4;
  localparam int FLB_T2  = 5;
  localparam int FLB_T1  = 6;

  // auxiliary control bit positions
  localparam int ACR_T2_HOLD = 5;
  localparam int ACR_T1_FREE = 6;

  typedef struct packed {
    logic start;
    logic clear;
  } rem_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_sts_t;

endpackage

// ===== rtl/core/vif_ram.sv =====
module vif_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/vif_rem.sv =====
module vif_rem #(
  parameter int WIDTH = vif_pkg::TIMER_W
) (
  input  logic                clk,
  input  logic                rst,
  input  vif_pkg::rem_ctl_t   ctl,
  input  logic [WIDTH-1:0]    dividend,
  input  logic [WIDTH-1:0]    divisor,
  output vif_pkg::rem_sts_t   sts,
  output logic [WIDTH-1:0]    remainder
);

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t           state;
  logic [CW-1:0]    cnt;
  logic [WIDTH-1:0] dvd;
  logic [WIDTH-1:0] dvs;
  logic [WIDTH:0]   rem_sh;
  logic [WIDTH:0]   rem_diff;
  logic             rem_ge;

  // one restoring step: bring down the next dividend bit
  assign rem_sh   = {remainder, dvd[WIDTH-1]};
  assign rem_diff = rem_sh - {1'b0, dvs};
  assign rem_ge   = !rem_diff[WIDTH];

  assign sts.busy = (state == ST_RUN);
  assign sts.done = (state == ST_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (ctl.start) begin
            dvd       <= dividend;
            dvs       <= divisor;
            remainder <= '0;
            cnt       <= '0;
            state     <= ST_RUN;
          end
        end
        ST_RUN: begin
          remainder <= rem_ge ? rem_diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
          dvd       <= {dvd[WIDTH-2:0], 1'b0};
          cnt       <= cnt + 1'b1;
          if (cnt == CW'(WIDTH - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (ctl.clear) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/versatile_interface_adapter.sv =====
// Interface adapter with two ports, two timers, set/clear interrupt flags and
// a key FIFO behind port A. Requests enter on the s_ group: s_tuser carries the
// kind (read, write, tick, key push), s_tdata the register offset, data byte,
// tick length and the pin levels of both ports. Every request gives exactly one
// response on the m_ group with the read byte, the key acceptance bit, the
// interrupt line and both port drive bytes as they stand after the request.
// An accepted request passes from an input register through the register update
// logic, which loads the response register. Throughput is one request per cycle
// while the receiver takes responses and no remainder is pending. A tick that
// expires timer 1 in free-running mode with an overshoot at least as large as a
// nonzero reload needs the remainder of overshoot by reload; the bit-serial
// remainder unit holds that request until done, one quotient bit per cycle.
// Reset clears the control registers, the interrupt state and the FIFO pointers; the
// FIFO storage needs no clearing pass since the fill count guards every read.
// While the receiver stalls, the pending response holds and one more request
// waits in the input register; further requests are refused until it moves.
module versatile_interface_adapter #(
  parameter int KEY_FIFO_DEPTH = vif_pkg::KEY_FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [3:0] reg_addr, [11:4] write_data, [27:12] tick_cycles,
  // [35:28] pins_a, [43:36] pins_b, [47:44] zero
  input  logic [47:0] s_tdata,
  // [1:0] op
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] read_data, [8] key_accepted, [9] irq, [17:10] port_a_drive,
  // [25:18] port_b_drive, [31:26] zero
  output logic [31:0] m_tdata
);

  localparam int TW = vif_pkg::TIMER_W;
  localparam int AW = (KEY_FIFO_DEPTH > 1) ? $clog2(KEY_FIFO_DEPTH) : 1;
  localparam int FW = $clog2(KEY_FIFO_DEPTH + 1);

  // input register
  logic          s1_valid;
  vif_pkg::op_t  s1_op;
  logic [3:0]    s1_addr;
  logic [7:0]    s1_wdata;
  logic [TW-1:0] s1_cyc;
  logic [7:0]    s1_pa;
  logic [7:0]    s1_pb;

  // architectural state
  logic [7:0]    ora, orb, ddra, ddrb;
  logic [TW-1:0] t1_cnt, t1_rld, t2_cnt;
  logic          t1_act, t2_act;
  logic [7:0]    t2_lat, sr, acr, pcr;
  logic [6:0]    flags, ien;
  logic [AW-1:0] head, tail;
  logic [FW-1:0] fill;

  logic [7:0]    ora_next, orb_next, ddra_next, ddrb_next;
  logic [TW-1:0] t1_cnt_next, t1_rld_next, t2_cnt_next;
  logic          t1_act_next, t2_act_next;
  logic [7:0]    t2_lat_next, sr_next, acr_next, pcr_next;
  logic [6:0]    flags_next, ien_next;
  logic [AW-1:0] head_next, tail_next;
  logic [FW-1:0] fill_next;

  logic [7:0]    rd_byte;
  logic          acc;
  logic          pop;
  logic          push;
  logic          irq_next;

  logic          out_free;
  logic          s1_fire;
  logic          any_pend;

  // key FIFO read path
  logic [AW-1:0] head_inc, tail_inc;
  logic [AW-1:0] rd_addr;
  logic [7:0]    ram_q;
  logic          byp_valid;
  logic [7:0]    byp_data;
  logic [7:0]    key_data;

  // timer 1 expiry
  logic          t1_hit;
  logic [TW-1:0] t1_over;
  logic          t1_short;
  logic          need_div;
  logic [TW-1:0] t1_free_cnt;
  logic          t2_hit;

  vif_pkg::rem_ctl_t rem_ctl;
  vif_pkg::rem_sts_t rem_sts;
  logic [TW-1:0]     rem_val;

  assign out_free = !m_tvalid || m_tready;
  assign s1_fire  = s1_valid && out_free && (!need_div || rem_sts.done);
  assign s_tready = !s1_valid || s1_fire;
  assign any_pend = |(flags & ien);

  assign head_inc = (head == AW'(KEY_FIFO_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == AW'(KEY_FIFO_DEPTH - 1)) ? '0 : tail + 1'b1;
  // prefetch the entry at the head as it stands after this request
  assign rd_addr  = (s1_fire && pop) ? head_inc : head;
  assign key_data = byp_valid ? byp_data : ram_q;

  assign t1_hit   = t1_act && (t1_cnt <= s1_cyc);
  assign t1_over  = s1_cyc - t1_cnt;
  assign t1_short = t1_over < t1_rld;
  assign need_div = (s1_op == vif_pkg::OP_TICK) && t1_hit && acr[vif_pkg::ACR_T1_FREE]
                    && !t1_short && (t1_rld != '0);
  assign t2_hit   = t2_cnt <= s1_cyc;

  always_comb begin
    if (t1_short) begin
      t1_free_cnt = t1_rld - t1_over;
    end else if (t1_rld == '0) begin
      t1_free_cnt = '0;
    end else begin
      t1_free_cnt = t1_rld - rem_val;
    end
  end

  assign rem_ctl.start = s1_valid && need_div && !rem_sts.busy && !rem_sts.done;
  assign rem_ctl.clear = s1_fire;

  vif_rem #(
    .WIDTH(TW)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .ctl      (rem_ctl),
    .dividend (t1_over),
    .divisor  (t1_rld),
    .sts      (rem_sts),
    .remainder(rem_val)
  );

  vif_ram #(
    .WIDTH(8),
    .DEPTH(KEY_FIFO_DEPTH)
  ) u_key_ram (
    .clk  (clk),
    .we   (s1_fire && push),
    .waddr(tail),
    .wdata(s1_wdata),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  always_comb begin
    ora_next    = ora;
    orb_next    = orb;
    ddra_next   = ddra;
    ddrb_next   = ddrb;
    t1_cnt_next = t1_cnt;
    t1_rld_next = t1_rld;
    t1_act_next = t1_act;
    t2_cnt_next = t2_cnt;
    t2_lat_next = t2_lat;
    t2_act_next = t2_act;
    sr_next     = sr;
    acr_next    = acr;
    pcr_next    = pcr;
    flags_next  = flags;
    ien_next    = ien;
    head_next   = head;
    tail_next   = tail;
    fill_next   = fill;
    rd_byte     = '0;
    acc         = 1'b0;
    pop         = 1'b0;
    push        = 1'b0;

    unique case (s1_op)
      vif_pkg::OP_READ: begin
        unique case (s1_addr) inside
          vif_pkg::REG_ORB: begin
            flags_next[vif_pkg::FLB_CB1] = 1'b0;
            flags_next[vif_pkg::FLB_CB2] = 1'b0;
            rd_byte = (orb & ddrb) | (s1_pb & ~ddrb);
          end
          vif_pkg::REG_ORA, vif_pkg::REG_ORA2: begin
            flags_next[vif_pkg::FLB_CA1] = 1'b0;
            flags_next[vif_pkg::FLB_CA2] = 1'b0;
            if (ddra == '0 && fill != '0) begin
              pop       = 1'b1;
              rd_byte   = key_data;
              head_next = head_inc;
              fill_next = fill - 1'b1;
              // keys left behind raise CA1 again
              flags_next[vif_pkg::FLB_CA1] = (fill != FW'(1));
            end else begin
              rd_byte = (ora & ddra) | (s1_pa & ~ddra);
            end
          end
          vif_pkg::REG_DDRB: rd_byte = ddrb;
          vif_pkg::REG_DDRA: rd_byte = ddra;
          vif_pkg::REG_T1CL: begin
            flags_next[vif_pkg::FLB_T1] = 1'b0;
            rd_byte = t1_cnt[7:0];
          end
          vif_pkg::REG_T1CH: rd_byte = t1_cnt[15:8];
          vif_pkg::REG_T1LL: rd_byte = t1_rld[7:0];
          vif_pkg::REG_T1LH: rd_byte = t1_rld[15:8];
          vif_pkg::REG_T2CL: begin
            flags_next[vif_pkg::FLB_T2] = 1'b0;
            rd_byte = t2_cnt[7:0];
          end
          vif_pkg::REG_T2CH: rd_byte = t2_cnt[15:8];
          vif_pkg::REG_SR:   rd_byte = sr;
          vif_pkg::REG_ACR:  rd_byte = acr;
          vif_pkg::REG_PCR:  rd_byte = pcr;
          vif_pkg::REG_IFR:  rd_byte = {any_pend, flags};
          default:           rd_byte = {1'b1, ien};
        endcase
      end
      vif_pkg::OP_WRITE: begin
        unique case (s1_addr) inside
          vif_pkg::REG_ORB: begin
            orb_next = s1_wdata;
            flags_next[vif_pkg::FLB_CB1] = 1'b0;
            flags_next[vif_pkg::FLB_CB2] = 1'b0;
          end
          vif_pkg::REG_ORA, vif_pkg::REG_ORA2: begin
            ora_next = s1_wdata;
            flags_next[vif_pkg::FLB_CA1] = 1'b0;
            flags_next[vif_pkg::FLB_CA2] = 1'b0;
          end
          vif_pkg::REG_DDRB: ddrb_next = s1_wdata;
          vif_pkg::REG_DDRA: ddra_next = s1_wdata;
          vif_pkg::REG_T1CL, vif_pkg::REG_T1LL: t1_rld_next = {t1_rld[15:8], s1_wdata};
          vif_pkg::REG_T1LH: t1_rld_next = {s1_wdata, t1_rld[7:0]};
          vif_pkg::REG_T1CH: begin
            // load the high latch and start counting from the full latch
            t1_rld_next = {s1_wdata, t1_rld[7:0]};
            t1_cnt_next = {s1_wdata, t1_rld[7:0]};
            t1_act_next = 1'b1;
            flags_next[vif_pkg::FLB_T1] = 1'b0;
          end
          vif_pkg::REG_T2CL: t2_lat_next = s1_wdata;
          vif_pkg::REG_T2CH: begin
            t2_cnt_next = {s1_wdata, t2_lat};
            t2_act_next = 1'b1;
            flags_next[vif_pkg::FLB_T2] = 1'b0;
          end
          vif_pkg::REG_SR:  sr_next  = s1_wdata;
          vif_pkg::REG_ACR: acr_next = s1_wdata;
          vif_pkg::REG_PCR: pcr_next = s1_wdata;
          vif_pkg::REG_IFR: flags_next = flags & ~s1_wdata[6:0];
          default: begin
            if (s1_wdata[7]) begin
              ien_next = ien | s1_wdata[6:0];
            end else begin
              ien_next = ien & ~s1_wdata[6:0];
            end
          end
        endcase
      end
      vif_pkg::OP_TICK: begin
        if (t1_act) begin
          if (t1_hit) begin
            flags_next[vif_pkg::FLB_T1] = 1'b1;
            if (acr[vif_pkg::ACR_T1_FREE]) begin
              t1_cnt_next = t1_free_cnt;
            end else begin
              t1_cnt_next = '0;
              t1_act_next = 1'b0;
            end
          end else begin
            t1_cnt_next = t1_cnt - s1_cyc;
          end
        end
        if (t2_act && !acr[vif_pkg::ACR_T2_HOLD]) begin
          if (t2_hit) begin
            flags_next[vif_pkg::FLB_T2] = 1'b1;
            t2_cnt_next = '0;
            t2_act_next = 1'b0;
          end else begin
            t2_cnt_next = t2_cnt - s1_cyc;
          end
        end
      end
      vif_pkg::OP_PUSH: begin
        if (fill != FW'(KEY_FIFO_DEPTH)) begin
          push      = 1'b1;
          acc       = 1'b1;
          tail_next = tail_inc;
          fill_next = fill + 1'b1;
          flags_next[vif_pkg::FLB_CA1] = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign irq_next = |(flags_next & ien_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      m_tvalid  <= 1'b0;
      byp_valid <= 1'b0;
      ora       <= '0;
      orb       <= '0;
      ddra      <= '0;
      ddrb      <= '0;
      t1_cnt    <= '0;
      t1_rld    <= '0;
      t1_act    <= 1'b0;
      t2_cnt    <= '0;
      t2_lat    <= '0;
      t2_act    <= 1'b0;
      sr        <= '0;
      acr       <= '0;
      pcr       <= '0;
      flags     <= '0;
      ien       <= '0;
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (s1_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      // a push into the entry being prefetched bypasses the RAM read
      byp_valid <= s1_fire && push && (tail == rd_addr);
      if (s1_fire) begin
        ora    <= ora_next;
        orb    <= orb_next;
        ddra   <= ddra_next;
        ddrb   <= ddrb_next;
        t1_cnt <= t1_cnt_next;
        t1_rld <= t1_rld_next;
        t1_act <= t1_act_next;
        t2_cnt <= t2_cnt_next;
        t2_lat <= t2_lat_next;
        t2_act <= t2_act_next;
        sr     <= sr_next;
        acr    <= acr_next;
        pcr    <= pcr_next;
        flags  <= flags_next;
        ien    <= ien_next;
        head   <= head_next;
        tail   <= tail_next;
        fill   <= fill_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_op    <= vif_pkg::op_t'(s_tuser);
      s1_addr  <= s_tdata[3:0];
      s1_wdata <= s_tdata[11:4];
      s1_cyc   <= s_tdata[27:12];
      s1_pa    <= s_tdata[35:28];
      s1_pb    <= s_tdata[43:36];
    end
    byp_data <= s1_wdata;
    if (s1_fire) begin
      m_tdata <= {6'b0, orb_next & ddrb_next, ora_next & ddra_next, irq_next, acc, rd_byte};
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(KEY_FIFO_DEPTH))
    else $error("key FIFO fill count beyond depth");

  a_empty_aligned: assert property (@(posedge clk) disable iff (rst)
    fill == '0 |-> head == tail)
    else $error("key FIFO empty with head and tail apart");

  a_full_aligned: assert property (@(posedge clk) disable iff (rst)
    fill == FW'(KEY_FIFO_DEPTH) |-> head == tail)
    else $error("key FIFO full with head and tail apart");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    s1_fire |-> !m_tvalid || m_tready)
    else $error("response register overwritten while stalled");

  a_wait_rem: assert property (@(posedge clk) disable iff (rst)
    rem_sts.busy |-> !s1_fire && $stable(t1_cnt) && $stable(t1_rld))
    else $error("request completed while remainder unit still running");
`endif

endmodule
